>>> src/msc_pkg.sv
// Shared types and constants for the multi-phase sensor calibration block.
// Holds the port structs, the front-to-back command format and state encodings.
// No dependencies.
package msc_pkg;

    localparam int CHANNELS    = 4;
    localparam int SAMPLE_BITS = 12;
    localparam int PIDX_W      = 3;
    localparam int CH_IDX_W    = $clog2(CHANNELS);
    localparam int STEP_W      = $clog2(SAMPLE_BITS);
    localparam int CFG_W       = 16;
    localparam int TIME_W      = 32;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [SAMPLE_BITS-1:0] MIDSCALE = SAMPLE_BITS'(2048);
    localparam logic [CFG_W-1:0] SETTLE_RESET = 16'd3000;
    localparam logic [CFG_W-1:0] SAMPLE_RESET = 16'd2000;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic CFG_SETTLE = 1'b0;
    localparam logic CFG_SAMPLE = 1'b1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_BUSY = 2'd1;
    localparam logic [1:0] ST_NEXT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    typedef struct packed {
        logic        operation;
        logic [31:0] now_ms;
        logic [11:0] adc_0;
        logic [11:0] adc_1;
        logic [11:0] adc_2;
        logic [11:0] adc_3;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  phases_completed;
        logic        active;
        logic [2:0]  current_phase;
        logic        row_valid;
        logic [2:0]  row_index;
        logic [11:0] avg_0;
        logic [11:0] avg_1;
        logic [11:0] avg_2;
        logic [11:0] avg_3;
        logic        last;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_IDLE,
        CMD_SAMPLE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                             kind;
        logic                                  accum;
        logic                                  phase_end;
        logic                                  final_phase;
        logic [PIDX_W-1:0]                     phase;
        logic [CHANNELS-1:0][SAMPLE_BITS-1:0]  adc;
    } cmd_t;

    typedef enum logic [2:0] {
        BK_FETCH,
        BK_EXEC,
        BK_DIVGO,
        BK_DIVWAIT,
        BK_ROWWR,
        BK_RDROW,
        BK_ROWOUT,
        BK_RESP
    } back_state_t;

endpackage

>>> src/msc_fifo.sv
// Two-entry command queue between the front classifier and the back executor.
// Depends on msc_pkg for the command type and queue depth.
module msc_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  msc_pkg::cmd_t push_data,
    input  logic          pop,
    output msc_pkg::cmd_t pop_data,
    output logic          full,
    output logic          empty
);
    import msc_pkg::*;

    cmd_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == QCNT_W'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_W'(QDEPTH))
        else $error("queue count exceeds depth");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |-> !full)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("pop from an empty queue");

endmodule

>>> src/msc_front.sv
// Front end: configuration registers, phase timing and classification of transactions.
// Pushes one command per accepted transaction into the queue. Depends on msc_pkg.
module msc_front #(
    parameter int PHASES = 5
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  msc_pkg::in_item_t s_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_index,
    input  logic [15:0]      cfg_data,
    input  logic             q_full,
    output logic             q_push,
    output msc_pkg::cmd_t    q_data
);
    import msc_pkg::*;

    localparam int PH_W = $clog2(PHASES + 1);

    logic [PH_W-1:0]   phase_reg, phase_next;
    logic [TIME_W-1:0] start_reg, start_next;
    logic [CFG_W-1:0]  settle_reg, settle_next;
    logic [CFG_W-1:0]  sample_reg, sample_next;
    logic [CFG_W:0]    window_reg, window_next;

    logic [TIME_W-1:0] elapsed;
    logic              settled;
    logic              window_end;
    logic              is_final;

    assign s_ready   = !q_full;
    assign cfg_ready = 1'b1;
    assign q_push    = s_valid && !q_full;

    assign elapsed    = s_data.now_ms - start_reg;
    assign settled    = elapsed >= TIME_W'(settle_reg);
    assign window_end = (elapsed >= TIME_W'(window_reg)) || (sample_reg == '0);
    assign is_final   = (phase_reg == PH_W'(PHASES - 1));

    always_comb begin
        q_data.kind        = CMD_SAMPLE;
        q_data.accum       = settled;
        q_data.phase_end   = window_end;
        q_data.final_phase = is_final;
        q_data.phase       = PIDX_W'(phase_reg);
        q_data.adc[0]      = s_data.adc_0;
        q_data.adc[1]      = s_data.adc_1;
        q_data.adc[2]      = s_data.adc_2;
        q_data.adc[3]      = s_data.adc_3;
        phase_next         = phase_reg;
        start_next         = start_reg;
        if (s_data.operation == OP_START) begin
            q_data.kind = CMD_START;
        end else if (phase_reg >= PH_W'(PHASES)) begin
            q_data.kind = CMD_IDLE;
        end
        if (q_push) begin
            if (s_data.operation == OP_START) begin
                phase_next = '0;
                start_next = s_data.now_ms;
            end else if (phase_reg < PH_W'(PHASES) && window_end) begin
                phase_next = phase_reg + 1'b1;
                if (!is_final) begin
                    start_next = s_data.now_ms;
                end
            end
        end
    end

    always_comb begin
        settle_next = settle_reg;
        sample_next = sample_reg;
        window_next = window_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_SETTLE: begin
                    settle_next = cfg_data;
                    window_next = {1'b0, cfg_data} + {1'b0, sample_reg};
                end
                CFG_SAMPLE: begin
                    sample_next = cfg_data;
                    window_next = {1'b0, settle_reg} + {1'b0, cfg_data};
                end
                default: begin
                    settle_next = settle_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_W'(PHASES);
            start_reg  <= '0;
            settle_reg <= SETTLE_RESET;
            sample_reg <= SAMPLE_RESET;
            window_reg <= {1'b0, SETTLE_RESET} + {1'b0, SAMPLE_RESET};
        end else begin
            phase_reg  <= phase_next;
            start_reg  <= start_next;
            settle_reg <= settle_next;
            sample_reg <= sample_next;
            window_reg <= window_next;
        end
    end

endmodule

>>> src/msc_div.sv
// Restoring divider producing one quotient bit per cycle for the channel averages.
// The quotient is known to fit in the sample width. Depends on msc_pkg.
module msc_div #(
    parameter int COUNT_BITS = 16
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     start,
    input  logic [msc_pkg::SAMPLE_BITS+COUNT_BITS-1:0] dividend,
    input  logic [COUNT_BITS-1:0]                    divisor,
    output logic                                     busy,
    output logic                                     done,
    output logic [msc_pkg::SAMPLE_BITS-1:0]          quotient
);
    import msc_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + COUNT_BITS;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [SUM_W-1:0]       rem_reg, rem_next;
    logic [SUM_W-1:0]       dsh_reg, dsh_next;
    logic [SAMPLE_BITS-1:0] quo_reg, quo_next;
    logic                   fits;

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;
    assign fits     = rem_reg >= dsh_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = STEP_W'(SAMPLE_BITS - 1);
            rem_next  = dividend;
            dsh_next  = SUM_W'({divisor, {(SAMPLE_BITS-1){1'b0}}});
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = rem_reg - dsh_reg;
            end
            quo_next = {quo_reg[SAMPLE_BITS-2:0], fits};
            dsh_next = dsh_reg >> 1;
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                step_next = step_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg <= step_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quo_reg  <= quo_next;
    end

endmodule

>>> src/msc_back.sv
// Back end: accumulators, phase averaging, profile table and result register.
// Executes queued commands in order. Depends on msc_pkg and msc_div.
module msc_back #(
    parameter int PHASES     = 5,
    parameter int COUNT_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_empty,
    input  msc_pkg::cmd_t      q_data,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output msc_pkg::out_item_t m_data
);
    import msc_pkg::*;

    localparam int SUM_W = SAMPLE_BITS + COUNT_BITS;
    localparam int TA_W  = (PHASES > 1) ? $clog2(PHASES) : 1;

    back_state_t state_reg, state_next;
    cmd_t        cmd_reg, cmd_next;

    logic [SUM_W-1:0]                     sums_reg [CHANNELS];
    logic [SUM_W-1:0]                     sums_next [CHANNELS];
    logic [COUNT_BITS-1:0]                count_reg, count_next;
    logic [CH_IDX_W-1:0]                  ch_reg, ch_next;
    logic [CHANNELS-1:0][SAMPLE_BITS-1:0] quo_reg, quo_next;
    logic [PIDX_W-1:0]                    rd_idx_reg, rd_idx_next;
    logic [CHANNELS-1:0][SAMPLE_BITS-1:0] rd_data_reg;
    logic [CHANNELS-1:0][SAMPLE_BITS-1:0] table_mem [PHASES];
    logic                                 m_valid_reg, m_valid_next;
    out_item_t                            m_data_reg, m_data_next;

    logic                   out_free;
    logic                   last_ch;
    logic                   last_row;
    logic                   div_start;
    logic                   div_busy;
    logic                   div_done;
    logic [SAMPLE_BITS-1:0] div_q;

    assign out_free = !m_valid_reg || m_ready;
    assign last_ch  = (ch_reg == CH_IDX_W'(CHANNELS - 1));
    assign last_row = (rd_idx_reg == PIDX_W'(PHASES - 1));
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    msc_div #(
        .COUNT_BITS(COUNT_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sums_reg[ch_reg]),
        .divisor  (count_reg),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_FETCH: begin
                if (!q_empty) begin
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC: begin
                if (cmd_reg.kind == CMD_SAMPLE && cmd_reg.phase_end) begin
                    state_next = BK_DIVGO;
                end else begin
                    state_next = BK_RESP;
                end
            end
            BK_DIVGO: begin
                if (count_reg != '0) begin
                    state_next = BK_DIVWAIT;
                end else if (last_ch) begin
                    state_next = BK_ROWWR;
                end
            end
            BK_DIVWAIT: begin
                if (div_done) begin
                    state_next = last_ch ? BK_ROWWR : BK_DIVGO;
                end
            end
            BK_ROWWR: begin
                state_next = cmd_reg.final_phase ? BK_RDROW : BK_RESP;
            end
            BK_RDROW: begin
                state_next = BK_ROWOUT;
            end
            BK_ROWOUT: begin
                if (out_free) begin
                    state_next = last_row ? BK_FETCH : BK_RDROW;
                end
            end
            BK_RESP: begin
                if (out_free) begin
                    state_next = BK_FETCH;
                end
            end
            default: begin
                state_next = BK_FETCH;
            end
        endcase
    end

    always_comb begin
        q_pop        = 1'b0;
        div_start    = 1'b0;
        cmd_next     = cmd_reg;
        sums_next    = sums_reg;
        count_next   = count_reg;
        ch_next      = ch_reg;
        quo_next     = quo_reg;
        rd_idx_next  = rd_idx_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        case (state_reg)
            BK_FETCH: begin
                if (!q_empty) begin
                    q_pop    = 1'b1;
                    cmd_next = q_data;
                end
            end
            BK_EXEC: begin
                ch_next = '0;
                if (cmd_reg.kind == CMD_START) begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        sums_next[c] = '0;
                    end
                    count_next = '0;
                end else if (cmd_reg.kind == CMD_SAMPLE && cmd_reg.accum
                             && count_reg != {COUNT_BITS{1'b1}}) begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        sums_next[c] = sums_reg[c] + SUM_W'(cmd_reg.adc[c]);
                    end
                    count_next = count_reg + 1'b1;
                end
            end
            BK_DIVGO: begin
                if (count_reg == '0) begin
                    quo_next[ch_reg] = MIDSCALE;
                    ch_next          = ch_reg + 1'b1;
                end else begin
                    div_start = 1'b1;
                end
            end
            BK_DIVWAIT: begin
                if (div_done) begin
                    quo_next[ch_reg] = div_q;
                    ch_next          = ch_reg + 1'b1;
                end
            end
            BK_ROWWR: begin
                rd_idx_next = '0;
                if (!cmd_reg.final_phase) begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        sums_next[c] = '0;
                    end
                    count_next = '0;
                end
            end
            BK_RDROW: begin
                rd_idx_next = rd_idx_reg;
            end
            BK_ROWOUT: begin
                if (out_free) begin
                    m_valid_next                 = 1'b1;
                    m_data_next.status           = ST_DONE;
                    m_data_next.phases_completed = 3'(PHASES);
                    m_data_next.active           = 1'b0;
                    m_data_next.current_phase    = '0;
                    m_data_next.row_valid        = 1'b1;
                    m_data_next.row_index        = rd_idx_reg;
                    m_data_next.avg_0            = rd_data_reg[0];
                    m_data_next.avg_1            = rd_data_reg[1];
                    m_data_next.avg_2            = rd_data_reg[2];
                    m_data_next.avg_3            = rd_data_reg[3];
                    m_data_next.last             = last_row;
                    rd_idx_next                  = rd_idx_reg + 1'b1;
                end
            end
            BK_RESP: begin
                if (out_free) begin
                    m_valid_next                 = 1'b1;
                    m_data_next                  = '0;
                    m_data_next.last             = 1'b1;
                    case (cmd_reg.kind)
                        CMD_START: begin
                            m_data_next.status = ST_BUSY;
                            m_data_next.active = 1'b1;
                        end
                        CMD_SAMPLE: begin
                            m_data_next.active = 1'b1;
                            if (cmd_reg.phase_end) begin
                                m_data_next.status           = ST_NEXT;
                                m_data_next.phases_completed = cmd_reg.phase + 1'b1;
                                m_data_next.current_phase    = cmd_reg.phase + 1'b1;
                            end else begin
                                m_data_next.status        = ST_BUSY;
                                m_data_next.current_phase = cmd_reg.phase;
                            end
                        end
                        default: begin
                            m_data_next.status = ST_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_FETCH;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
            for (int c = 0; c < CHANNELS; c++) begin
                sums_reg[c] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
            sums_reg    <= sums_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        ch_reg     <= ch_next;
        quo_reg    <= quo_next;
        rd_idx_reg <= rd_idx_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (state_reg == BK_ROWWR) begin
            table_mem[cmd_reg.phase[TA_W-1:0]] <= quo_reg;
        end
        if (state_reg == BK_RDROW) begin
            rd_data_reg <= table_mem[rd_idx_reg[TA_W-1:0]];
        end
    end

    a_row_only_when_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.row_valid |-> m_data_reg.status == ST_DONE)
        else $error("profile row carried outside a completed run");

    a_burst_only_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_data_reg.last |-> m_data_reg.row_valid)
        else $error("non-final result that is not a profile row");

    a_div_idle_on_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

endmodule

>>> src/multi_phase_sensor_calibration.sv
// Five-phase calibration sequencer for four 12-bit sensor channels.
// Transactions pass through the queue to the back end; a phase end also averages each channel
// in turn in the shared one-bit-per-cycle divider, and a run end emits one profile row per phase.
// The front end accepts transactions while the queue has room; the back end works on one at a time.
// Reset is synchronous and active low; the block comes up idle with default timing registers.
module multi_phase_sensor_calibration #(
    parameter int PHASES     = 5,
    parameter int COUNT_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  msc_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output msc_pkg::out_item_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [15:0]        cfg_data
);
    import msc_pkg::*;

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    cmd_t q_in;
    cmd_t q_out;

    msc_front #(
        .PHASES(PHASES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    msc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    msc_back #(
        .PHASES     (PHASES),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
